>>> design/cmae_pkg.sv
package cmae_pkg;

    localparam int ANGLE_W = 16;
    localparam int SUM_W   = 27;
    localparam int UNIT_W  = 17;
    localparam int XY_W    = 30;
    localparam int Z_W     = 32;
    localparam int STEP_W  = 5;
    localparam int TAB_LEN = 24;

    localparam logic signed [XY_W-1:0] GAIN_START = XY_W'(39797);
    localparam logic signed [XY_W-1:0] UNIT_CLAMP = XY_W'(65535);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               last;
        logic               keep;
    } cmae_item_t;

    typedef struct packed {
        logic start;
        logic vec;
    } cmae_cordic_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_VEC_START,
        ST_VEC,
        ST_DEV,
        ST_DIV,
        ST_OUT
    } cmae_state_t;

    // atan(2^-i) in binary angle units, pi = 2^31
    function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [Z_W-1:0] r;
        begin
            case (idx)
                5'd0:    r = 32'd536870912;
                5'd1:    r = 32'd316933406;
                5'd2:    r = 32'd167458907;
                5'd3:    r = 32'd85004756;
                5'd4:    r = 32'd42667331;
                5'd5:    r = 32'd21354465;
                5'd6:    r = 32'd10680862;
                5'd7:    r = 32'd5340245;
                5'd8:    r = 32'd2670163;
                5'd9:    r = 32'd1335087;
                5'd10:   r = 32'd667544;
                5'd11:   r = 32'd333772;
                5'd12:   r = 32'd166886;
                5'd13:   r = 32'd83443;
                5'd14:   r = 32'd41722;
                5'd15:   r = 32'd20861;
                5'd16:   r = 32'd10430;
                5'd17:   r = 32'd5215;
                5'd18:   r = 32'd2608;
                5'd19:   r = 32'd1304;
                5'd20:   r = 32'd652;
                5'd21:   r = 32'd326;
                5'd22:   r = 32'd163;
                5'd23:   r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/cmae_front.sv
module cmae_front
    import cmae_pkg::*;
#(
    parameter int MAX_ANGLES = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ANGLE_W-1:0]  s_axis_tdata,   // angle
    input  logic                s_axis_tlast,   // last_angle
    output logic                item_valid,
    output cmae_item_t          item,
    input  logic                item_pop
);

    localparam int CNT_W = $clog2(MAX_ANGLES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ANGLES);

    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       level_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    cmae_item_t       q_mem [2];
    logic             push;
    logic             keep;

    assign s_axis_tready = (level_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign keep          = (cnt_reg != MAX_CNT);
    assign item_valid    = (level_reg != 2'd0);
    assign item          = q_mem[rd_ptr_reg];

    // classify: count the set so far, mark words past the store depth as drops
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            level_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else begin
            if (push) begin
                if (s_axis_tlast)
                    cnt_reg <= '0;
                else if (keep)
                    cnt_reg <= cnt_reg + 1'b1;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !item_pop)
                level_reg <= level_reg + 2'd1;
            else if (!push && item_pop)
                level_reg <= level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{angle: s_axis_tdata, last: s_axis_tlast, keep: keep};
        end
    end

endmodule

>>> design/cmae_cordic.sv
module cmae_cordic
    import cmae_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmae_cordic_req_t          req,
    input  logic [ANGLE_W-1:0]        angle,
    input  logic signed [SUM_W-1:0]   cx,
    input  logic signed [SUM_W-1:0]   sy,
    output logic                      done,
    output logic signed [UNIT_W-1:0]  cosv,
    output logic signed [UNIT_W-1:0]  sinv,
    output logic [Z_W-1:0]            zout
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic                   vec_reg;
    logic [STEP_W-1:0]      step_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic [Z_W-1:0]         z_reg;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] cx_ext;
    logic signed [XY_W-1:0] sy_ext;
    logic [Z_W-1:0]         t;
    logic                   neg;

    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign t      = atan_entry(step_reg);
    assign neg    = vec_reg ? !y_reg[XY_W-1] : z_reg[Z_W-1];
    assign cx_ext = XY_W'(cx);
    assign sy_ext = XY_W'(sy);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            step_reg <= '0;
        end
        else begin
            done_reg <= !req.start && busy_reg && (step_reg == LAST_STEP);
            if (req.start) begin
                busy_reg <= 1'b1;
                vec_reg  <= req.vec;
                step_reg <= '0;
            end
            else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            if (req.vec) begin
                // left half-plane: mirror the vector and start from pi
                if (cx_ext < 0) begin
                    x_reg <= -cx_ext;
                    y_reg <= -sy_ext;
                    z_reg <= {1'b1, {(Z_W-1){1'b0}}};
                end
                else begin
                    x_reg <= cx_ext;
                    y_reg <= sy_ext;
                    z_reg <= '0;
                end
            end
            else begin
                y_reg <= '0;
                if (angle[ANGLE_W-1] ^ angle[ANGLE_W-2]) begin
                    x_reg <= -GAIN_START;
                    z_reg <= {~angle[ANGLE_W-1], angle[ANGLE_W-2:0], 16'd0};
                end
                else begin
                    x_reg <= GAIN_START;
                    z_reg <= {angle, 16'd0};
                end
            end
        end
        else if (busy_reg) begin
            if (neg) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
            else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
        end
    end

    always_comb begin
        if (x_reg > UNIT_CLAMP)
            cosv = UNIT_W'(UNIT_CLAMP);
        else if (x_reg < -UNIT_CLAMP)
            cosv = UNIT_W'(-UNIT_CLAMP);
        else
            cosv = UNIT_W'(x_reg);
        if (y_reg > UNIT_CLAMP)
            sinv = UNIT_W'(UNIT_CLAMP);
        else if (y_reg < -UNIT_CLAMP)
            sinv = UNIT_W'(-UNIT_CLAMP);
        else
            sinv = UNIT_W'(y_reg);
    end

    assign done = done_reg;
    assign zout = z_reg;

endmodule

>>> design/cmae_back.sv
module cmae_back
    import cmae_pkg::*;
#(
    parameter int MAX_ANGLES   = 1024,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  cmae_item_t   item,
    output logic         item_pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // mean_direction, mean_deviation
    output logic         m_axis_tuser    // dropped_any
);

    localparam int CNT_W  = $clog2(MAX_ANGLES + 1);
    localparam int ADDR_W = $clog2(MAX_ANGLES);
    localparam int DSUM_W = CNT_W + ANGLE_W;
    localparam int DCNT_W = $clog2(DSUM_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DSUM_W - 1);

    cmae_state_t              state_reg, state_next;
    logic [ANGLE_W-1:0]       store_mem [MAX_ANGLES];
    logic [ANGLE_W-1:0]       rd_data_reg;
    logic signed [SUM_W-1:0]  csum_reg;
    logic signed [SUM_W-1:0]  ssum_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     drop_reg;
    logic                     last_reg;
    logic [ANGLE_W-1:0]       mean_reg;
    logic [CNT_W-1:0]         rd_idx_reg;
    logic                     rd_pend_reg;
    logic [DSUM_W-1:0]        dsum_reg;
    logic [DSUM_W-1:0]        quot_reg;
    logic [CNT_W:0]           rem_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic                     out_valid_reg;
    logic [31:0]              out_data_reg;
    logic                     out_user_reg;

    cmae_cordic_req_t         creq;
    logic                     cdone;
    logic signed [UNIT_W-1:0] cosv;
    logic signed [UNIT_W-1:0] sinv;
    logic [Z_W-1:0]           zout;
    logic                     rd_issue;
    logic [ANGLE_W-1:0]       diff;
    logic [ANGLE_W-1:0]       wrap_dist;
    logic [CNT_W:0]           trial;
    logic                     out_free;
    logic [Z_W-1:0]           zround;

    cmae_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .angle (item.angle),
        .cx    (csum_reg),
        .sy    (ssum_reg),
        .done  (cdone),
        .cosv  (cosv),
        .sinv  (sinv),
        .zout  (zout)
    );

    assign rd_issue  = (rd_idx_reg != count_reg);
    assign diff      = rd_data_reg - mean_reg;
    assign wrap_dist = (diff > 16'h8000) ? (16'd0 - diff) : diff;
    assign trial     = {rem_reg[CNT_W-1:0], quot_reg[DSUM_W-1]};
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign zround    = zout + 32'h0000_8000;

    always_comb begin
        state_next = state_reg;
        item_pop   = 1'b0;
        creq       = '{start: 1'b0, vec: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_pop = 1'b1;
                    if (item.keep) begin
                        creq       = '{start: 1'b1, vec: 1'b0};
                        state_next = ST_ROT;
                    end
                    else if (item.last) begin
                        state_next = ST_VEC_START;
                    end
                end
            end
            ST_ROT: begin
                if (cdone)
                    state_next = last_reg ? ST_VEC_START : ST_IDLE;
            end
            ST_VEC_START: begin
                if (csum_reg == '0 && ssum_reg == '0) begin
                    state_next = ST_DEV;
                end
                else begin
                    creq       = '{start: 1'b1, vec: 1'b1};
                    state_next = ST_VEC;
                end
            end
            ST_VEC: begin
                if (cdone)
                    state_next = ST_DEV;
            end
            ST_DEV: begin
                if (!rd_issue && !rd_pend_reg)
                    state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            csum_reg      <= '0;
            ssum_reg      <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            last_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            rd_pend_reg <= (state_reg == ST_DEV) && rd_issue;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        last_reg <= item.last;
                        if (!item.keep)
                            drop_reg <= 1'b1;
                    end
                end
                ST_ROT: begin
                    if (cdone) begin
                        csum_reg  <= csum_reg + SUM_W'(cosv);
                        ssum_reg  <= ssum_reg + SUM_W'(sinv);
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        csum_reg      <= '0;
                        ssum_reg      <= '0;
                        count_reg     <= '0;
                        drop_reg      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // store writes, mean capture, deviation pass, divider and result payload
    always_ff @(posedge clk) begin
        if (state_reg == ST_IDLE && item_valid && item.keep)
            store_mem[count_reg[ADDR_W-1:0]] <= item.angle;
        rd_data_reg <= store_mem[rd_idx_reg[ADDR_W-1:0]];

        unique case (state_reg)
            ST_VEC_START: begin
                mean_reg   <= '0;
                rd_idx_reg <= '0;
                dsum_reg   <= '0;
            end
            ST_VEC: begin
                if (cdone)
                    mean_reg <= zround[Z_W-1:Z_W-ANGLE_W];
            end
            ST_DEV: begin
                if (rd_issue)
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_pend_reg)
                    dsum_reg <= dsum_reg + DSUM_W'(wrap_dist);
                quot_reg    <= dsum_reg + (rd_pend_reg ? DSUM_W'(wrap_dist) : '0);
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (trial >= {1'b0, count_reg}) begin
                    rem_reg  <= trial - {1'b0, count_reg};
                    quot_reg <= {quot_reg[DSUM_W-2:0], 1'b1};
                end
                else begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[DSUM_W-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_data_reg <= {(count_reg == '0) ? 16'd0 : quot_reg[ANGLE_W-1:0],
                                     mean_reg};
                    out_user_reg <= drop_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> design/circular_mean_angle_engine_core.sv
// Circular mean of a set of binary angles (1 unit = pi/32768).
// Input stream s_axis: one angle per word in tdata[15:0], tlast marks the
// final angle of a set. Output stream m_axis: one word per set, tdata[15:0]
// is the mean direction, tdata[31:16] the mean absolute wrapped deviation,
// tuser is set when angles beyond MAX_ANGLES were dropped from the set.
// Processing: the back end takes one angle at a time; a stored angle is
// rotated in the iterative CORDIC unit, a dropped angle only leaves the
// queue. After the last angle the unit vectors the summed pair (skipped
// when both sums are zero), a deviation pass reads the angle store (one
// read port), and bit-serial division gives the mean deviation.
// A two-word queue sits between the front classifier and the back end, so
// the input takes up to two words ahead while the back end works.
// Reset clears the sums, counts, queue and output valid; the angle store
// needs no clearing since only angles of the current set are read.
// When the receiver stalls, the result holds in the output register and the
// back end waits on it; the queue fills and then tready drops.
module circular_mean_angle_engine_core
    import cmae_pkg::*;
#(
    parameter int MAX_ANGLES   = 1024,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // angle
    input  logic         s_axis_tlast,   // last_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // mean_direction, mean_deviation
    output logic         m_axis_tuser    // dropped_any
);

    logic       item_valid;
    cmae_item_t item;
    logic       item_pop;

    // front: accept words, mark store/drop, queue them
    cmae_front #(
        .MAX_ANGLES (MAX_ANGLES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // back: CORDIC sums, store, vectoring, deviation pass, divide, result
    cmae_back #(
        .MAX_ANGLES   (MAX_ANGLES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> test/circular_mean_angle_engine_core_checker.sv
module circular_mean_angle_engine_core_checker #(
    parameter int MAX_ANGLES   = 1024,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // angle
    input  logic        s_axis_tlast,   // last_angle
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // mean_direction, mean_deviation
    input  logic        m_axis_tuser,   // dropped_any
    output int          mismatches,
    output int          pending
);

    typedef struct {
        logic [15:0] direction;
        logic [15:0] deviation;
        logic        dropped;
    } set_summary_t;

    localparam longint ARCTAN_LUT [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    set_summary_t summaries[$];
    logic [15:0]  held_angles [MAX_ANGLES];
    longint       cos_acc;
    longint       sin_acc;
    int           held_count;
    logic         overflowed;

    function automatic longint clamp_unit(input longint v);
        if (v > 65535)
            return 65535;
        if (v < -65535)
            return -65535;
        return v;
    endfunction

    // cosine and sine of one angle, iterative rotation
    task automatic rotate_angle(input logic [15:0] a, output longint c, output longint s);
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        logic [31:0] z;
        x = 39797;
        y = 0;
        z = {a, 16'h0000};
        if (z[30] ^ z[31])
        begin
            x = -x;
            z = z + 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (z[31])
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + 32'(ARCTAN_LUT[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - 32'(ARCTAN_LUT[i]);
            end
            x = nx;
            y = ny;
        end
        c = clamp_unit(x);
        s = clamp_unit(y);
    endtask

    // direction of the summed vector as a 32-bit binary angle
    function automatic logic [31:0] vector_angle(input longint cx, input longint sy);
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        logic [31:0] z;
        x = cx;
        y = sy;
        z = 32'h0;
        if (cx == 0 && sy == 0)
            return 32'h0;
        if (cx < 0)
        begin
            x = -cx;
            y = -sy;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (y < 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - 32'(ARCTAN_LUT[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + 32'(ARCTAN_LUT[i]);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    task automatic absorb_angle(input logic [15:0] a, input logic is_last);
        longint       c;
        longint       s;
        logic [31:0]  z;
        logic [15:0]  m;
        logic [15:0]  d;
        longint       dev_total;
        set_summary_t r;
        if (held_count < MAX_ANGLES)
        begin
            held_angles[held_count] = a;
            rotate_angle(a, c, s);
            cos_acc = cos_acc + c;
            sin_acc = sin_acc + s;
            held_count++;
        end
        else
            overflowed = 1'b1;
        if (is_last)
        begin
            z = vector_angle(cos_acc, sin_acc);
            z = z + 32'h8000;
            m = z[31:16];
            dev_total = 0;
            for (int k = 0; k < held_count; k++)
            begin
                d = held_angles[k] - m;
                if (d > 16'h8000)
                    d = 16'h0 - d;     // take the short way around
                dev_total += d;
            end
            r.direction = m;
            r.deviation = (held_count != 0) ? 16'(dev_total / held_count) : 16'h0;
            r.dropped   = overflowed;
            summaries.insert(summaries.size(), r);
            cos_acc    = 0;
            sin_acc    = 0;
            held_count = 0;
            overflowed = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_summary_t e;
        if (!rst_n)
        begin
            summaries.delete();
            cos_acc    = 0;
            sin_acc    = 0;
            held_count = 0;
            overflowed = 1'b0;
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_angle(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (summaries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: data %h user %b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    e = summaries.pop_front();
                    if (m_axis_tdata[15:0] !== e.direction ||
                        m_axis_tdata[31:16] !== e.deviation ||
                        m_axis_tuser !== e.dropped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp dir %h dev %h drop %b, ",
                                      "got dir %h dev %h drop %b"},
                                     e.direction, e.deviation, e.dropped,
                                     m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tuser);
                    end
                end
            end
            pending = summaries.size();
        end
    end

endmodule

>>> test/circular_mean_angle_engine_core_tb.sv
module circular_mean_angle_engine_core_tb;

    localparam int STALL_LIMIT = 6000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // angle
    logic        s_axis_tlast;    // last_angle
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // mean_direction, mean_deviation
    logic        m_axis_tuser;    // dropped_any

    int   mismatches;
    int   pending;
    logic gaps_on;
    logic long_hold;
    int   quiet_cycles;

    circular_mean_angle_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    circular_mean_angle_engine_core_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // drop the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("circular_mean_angle_engine_core: mismatch");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int   burst;
        logic hold_taken;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_taken)
            begin
                hold_taken    = 1'b1;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 7);
                m_axis_tready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic [15:0] a, input logic is_last);
        int burst;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            burst = $urandom_range(1, 7);
            s_axis_tvalid = 1'b0;
            repeat (burst) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = a;
        s_axis_tlast  = is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // angles clustered around a center, or spread over the whole circle
    function automatic logic [15:0] pick_angle(input logic [15:0] center, input int spread);
        if (spread == 0)
            return 16'($urandom);
        return center + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic send_set(input int len, input int spread);
        logic [15:0] center;
        center = 16'($urandom);
        for (int i = 0; i < len; i++)
            send_word(pick_angle(center, spread), i == len - 1);
    endtask

    initial
    begin
        int len;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0;
        s_axis_tlast  = 1'b0;
        gaps_on       = 1'b1;
        long_hold     = 1'b0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // extremes, single-angle sets, axis angles
        send_word(16'h0000, 1'b1);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'h4000, 1'b1);
        send_word(16'hC000, 1'b1);
        send_word(16'h3FFF, 1'b1);
        send_word(16'hBFFF, 1'b1);
        // opposite angles cancel: both sums zero
        send_word(16'h0000, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h4000, 1'b0);
        send_word(16'hC000, 1'b1);
        // set straddling the wrap point
        send_word(16'h7F00, 1'b0);
        send_word(16'h8100, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        // wide spread, large deviation
        send_word(16'h0001, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);

        // fill the store and overflow it; the final angle is dropped too
        for (int i = 0; i < 1028; i++)
            send_word(16'($urandom), i == 1027);

        // pause until the pipeline drains, then a tiny set behind it
        wait (pending == 0);
        repeat (1100) @(negedge clk);
        send_set(3, 2000);

        for (int n = 0; n < 16; n++)
        begin
            if (n == 4)
                long_hold = 1'b1;      // back end fills while the sender keeps offering
            if (n == 12)
                gaps_on = 1'b0;        // finish with back-to-back traffic
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            send_set(len, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12000));
        end

        wait (pending == 0);
        repeat (1200) @(negedge clk);
        if (mismatches == 0)
            $display("circular_mean_angle_engine_core: match");
        else
            $display("circular_mean_angle_engine_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
design/cmae_pkg.sv
design/cmae_front.sv
design/cmae_cordic.sv
design/cmae_back.sv
design/circular_mean_angle_engine_core.sv
test/circular_mean_angle_engine_core_checker.sv
test/circular_mean_angle_engine_core_tb.sv
